FILE: rtl/core/ssf_pkg.sv
// Shared constants and types of the shortest-seek-first scheduler.
package ssf_pkg;

    localparam int MAX_REQUESTS  = 64;
    localparam int TRACK_BITS    = 16;
    localparam int IDX_BITS      = $clog2(MAX_REQUESTS);
    localparam int CNT_BITS      = $clog2(MAX_REQUESTS + 1);
    localparam int SUM_BITS      = 22;
    localparam int OUT_DATA_BITS = 56;
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // Best candidate found so far, passed from one cell to the next.
    typedef struct packed {
        logic                  valid;
        logic [TRACK_BITS-1:0] distance;
        logic [IDX_BITS-1:0]   idx;
        logic [TRACK_BITS-1:0] track;
    } cand_t;

    // Broadcast control from the scheduler to every cell.
    typedef struct packed {
        logic                  load_en;
        logic [IDX_BITS-1:0]   load_idx;
        logic [TRACK_BITS-1:0] load_track;
        logic                  clear_en;
        logic [IDX_BITS-1:0]   clear_idx;
        logic [TRACK_BITS-1:0] head;
    } ctrl_t;

endpackage

FILE: rtl/core/shortest_seek_first_scheduler.sv
// Shortest-seek-first scheduler: loads a batch of track requests and serves them nearest first.
// Requests are taken one per cycle into a row of 64 cells until a transfer with tlast; the
// batch is then served starting from start_position, one result per request, with ties going
// to the earliest loaded request. For each pick the best candidate travels the whole row of
// cells, one cell per cycle, against the current head, and the pick is committed once the
// output register is free. No input is taken while a batch is being served. Requests beyond
// 64 are dropped and every result of that batch has tuser set.
module shortest_seek_first_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,     // start_position
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [15:0] track
    input  logic        s_tlast,      // batch_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,      // [15:0] served_track, [31:16] seek_distance,
                                      // [53:32] total_seek, [55:54] zero
    output logic        m_tlast,      // final_pick
    output logic        m_tuser       // overflow
);
    import ssf_pkg::*;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                  state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   remaining_reg, remaining_next;
    logic [CNT_BITS-1:0]   scan_cnt_reg, scan_cnt_next;
    logic                  dropped_reg, dropped_next;
    logic [TRACK_BITS-1:0] head_reg, head_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [15:0]           start_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [15:0]           out_track_reg;
    logic [15:0]           out_dist_reg;
    logic [SUM_BITS-1:0]   out_sum_reg;
    logic                  out_last_reg;
    logic                  out_ovf_reg;

    ctrl_t                 ctrl;
    cand_t                 best;
    logic                  in_fire;
    logic                  has_room;
    logic                  pick;
    logic                  final_pick;
    logic [SUM_BITS:0]     sum_wide;

    ssf_cell_row u_row (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (ctrl),
        .best   (best)
    );

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == ST_LOAD);
    assign in_fire    = s_tvalid && s_tready;
    assign has_room   = (count_reg < CNT_BITS'(MAX_REQUESTS));
    assign pick       = (state_reg == ST_SCAN) && (scan_cnt_reg == CNT_BITS'(MAX_REQUESTS))
                        && (!out_valid_reg || m_tready);
    assign final_pick = (remaining_reg == CNT_BITS'(1));
    assign sum_wide   = {1'b0, sum_reg} + (SUM_BITS + 1)'(best.distance);

    always_comb begin
        ctrl.load_en    = in_fire && has_room;
        ctrl.load_idx   = count_reg[IDX_BITS-1:0];
        ctrl.load_track = s_tdata[TRACK_BITS-1:0];
        ctrl.clear_en   = pick;
        ctrl.clear_idx  = best.idx;
        ctrl.head       = head_reg;
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        remaining_next = remaining_reg;
        scan_cnt_next  = scan_cnt_reg;
        dropped_next   = dropped_reg;
        head_next      = head_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (state_reg == ST_SCAN && scan_cnt_reg != CNT_BITS'(MAX_REQUESTS)) begin
            scan_cnt_next = scan_cnt_reg + CNT_BITS'(1);
        end
        if (in_fire) begin
            if (has_room) begin
                count_next = count_reg + CNT_BITS'(1);
            end else begin
                dropped_next = 1'b1;
            end
            if (s_tlast) begin
                state_next     = ST_SCAN;
                remaining_next = has_room ? count_reg + CNT_BITS'(1) : count_reg;
                scan_cnt_next  = '0;
                head_next      = start_reg[TRACK_BITS-1:0];
                sum_next       = '0;
            end
        end
        if (pick) begin
            out_valid_next = 1'b1;
            head_next      = best.track;
            sum_next       = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_BITS-1:0];
            scan_cnt_next  = '0;
            remaining_next = remaining_reg - CNT_BITS'(1);
            if (final_pick) begin
                state_next   = ST_LOAD;
                count_next   = '0;
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            remaining_reg <= '0;
            scan_cnt_reg  <= '0;
            dropped_reg   <= 1'b0;
            head_reg      <= '0;
            sum_reg       <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            scan_cnt_reg  <= scan_cnt_next;
            dropped_reg   <= dropped_next;
            head_reg      <= head_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                start_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pick) begin
            out_track_reg <= 16'(best.track);
            out_dist_reg  <= 16'(best.distance);
            out_sum_reg   <= sum_next;
            out_last_reg  <= final_pick;
            out_ovf_reg   <= dropped_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_sum_reg, out_dist_reg, out_track_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    // The chain must always deliver a candidate when a pick is committed.
    a_pick_has_candidate: assert property (@(posedge aclk) disable iff (!aresetn)
        pick |-> best.valid)
        else $error("pick committed without a pending candidate");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(MAX_REQUESTS))
        else $error("request count beyond store depth");

    a_scan_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (remaining_reg != '0))
        else $error("serving with no remaining requests");

    a_final_returns_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (pick && final_pick) |=> (state_reg == ST_LOAD && count_reg == '0 && !dropped_reg))
        else $error("batch state not cleared after the final pick");

endmodule

FILE: rtl/core/ssf_cell.sv
// One request cell: holds a track, its pending mark, and one stage of the search chain.
module ssf_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ssf_pkg::IDX_BITS-1:0] cell_index,
    input  ssf_pkg::ctrl_t               ctrl,
    input  ssf_pkg::cand_t               cand_in,
    output ssf_pkg::cand_t               cand_out
);
    import ssf_pkg::*;

    logic [TRACK_BITS-1:0] track_reg;
    logic                  pending_reg;
    logic                  pending_next;
    cand_t                 cand_reg;
    cand_t                 cand_next;
    logic [TRACK_BITS-1:0] head_dist;

    assign head_dist = (track_reg >= ctrl.head) ? (track_reg - ctrl.head)
                                                : (ctrl.head - track_reg);

    always_comb begin
        pending_next = pending_reg;
        if (ctrl.clear_en && ctrl.clear_idx == cell_index) begin
            pending_next = 1'b0;
        end
        if (ctrl.load_en && ctrl.load_idx == cell_index) begin
            pending_next = 1'b1;
        end
    end

    // Strict compare keeps the earlier-loaded request on a tie.
    always_comb begin
        cand_next = cand_in;
        if (pending_reg && (!cand_in.valid || head_dist < cand_in.distance)) begin
            cand_next.valid    = 1'b1;
            cand_next.distance = head_dist;
            cand_next.idx      = cell_index;
            cand_next.track    = track_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            cand_reg    <= '0;
        end else begin
            pending_reg <= pending_next;
            cand_reg    <= cand_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_en && ctrl.load_idx == cell_index) begin
            track_reg <= ctrl.load_track;
        end
    end

    assign cand_out = cand_reg;

endmodule

FILE: rtl/core/ssf_cell_row.sv
// Row of request cells; the nearest pending request emerges at the far end.
module ssf_cell_row (
    input  logic           aclk,
    input  logic           aresetn,
    input  ssf_pkg::ctrl_t ctrl,
    output ssf_pkg::cand_t best
);
    import ssf_pkg::*;

    cand_t chain [MAX_REQUESTS+1];

    assign chain[0] = '0;

    for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
        ssf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_index(IDX_BITS'(i)),
            .ctrl      (ctrl),
            .cand_in   (chain[i]),
            .cand_out  (chain[i+1])
        );
    end

    assign best = chain[MAX_REQUESTS];

endmodule

FILE: sim/ssf_result_checker.sv
// Result checker for the shortest-seek-first scheduler: predicts every result and compares it.
module ssf_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,          // start_position
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,           // [15:0] track
    input  logic        s_tlast,           // batch_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,           // [15:0] served_track, [31:16] seek_distance,
                                           // [53:32] total_seek, [55:54] zero
    input  logic        m_tlast,           // final_pick
    input  logic        m_tuser,           // overflow
    output int          mismatches,
    output int          picks_outstanding
);

    typedef struct packed {
        logic [15:0]                   track;
        logic [15:0]                   seek;
        logic [ssf_pkg::SUM_BITS-1:0]  total;
        logic                          last_pick;
        logic                          dropped;
    } pick_t;

    logic [ssf_pkg::TRACK_BITS-1:0] track_store [ssf_pkg::MAX_REQUESTS];
    int                             stored_count;
    logic                           dropped_seen;
    logic [15:0]                    start_track;
    pick_t                          pending_picks [$];

    // Serves the loaded batch nearest first and queues one expected pick per request.
    task automatic serve_nearest_first();
        logic                       served [ssf_pkg::MAX_REQUESTS];
        logic [15:0]                head;
        logic [15:0]                cand_dist;
        logic [15:0]                best_dist;
        logic                       found;
        logic [ssf_pkg::SUM_BITS:0] sum;
        int                         best;
        pick_t                      pick;
        head = start_track;
        sum  = '0;
        for (int i = 0; i < ssf_pkg::MAX_REQUESTS; i++) served[i] = 1'b0;
        for (int k = 0; k < stored_count; k++) begin
            found     = 1'b0;
            best      = 0;
            best_dist = '0;
            for (int j = 0; j < stored_count; j++) begin
                if (!served[j]) begin
                    cand_dist = (track_store[j] >= head) ? track_store[j] - head
                                                         : head - track_store[j];
                    // Strictly smaller only, so a tie stays with the earlier request.
                    if (!found || cand_dist < best_dist) begin
                        found     = 1'b1;
                        best_dist = cand_dist;
                        best      = j;
                    end
                end
            end
            served[best] = 1'b1;
            sum = sum + (ssf_pkg::SUM_BITS + 1)'(best_dist);
            if (sum > {1'b0, ssf_pkg::SUM_MAX}) sum = {1'b0, ssf_pkg::SUM_MAX};
            head = track_store[best];
            pick.track     = head;
            pick.seek      = best_dist;
            pick.total     = sum[ssf_pkg::SUM_BITS-1:0];
            pick.last_pick = (k == stored_count - 1);
            pick.dropped   = dropped_seen;
            pending_picks.push_back(pick);
        end
        stored_count = 0;
        dropped_seen = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        pick_t want;
        if (!aresetn) begin
            stored_count = 0;
            dropped_seen = 1'b0;
            start_track  = '0;
            pending_picks.delete();
        end else begin
            if (cfg_valid && cfg_ready) start_track = cfg_data;
            // A result never stems from an item taken at the same edge, so check first.
            if (m_tvalid && m_tready) begin
                if (pending_picks.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = pending_picks.pop_front();
                    check_field("served_track", want.track, m_tdata[15:0]);
                    check_field("seek_distance", want.seek, m_tdata[31:16]);
                    check_field("total_seek", want.total, m_tdata[53:32]);
                    check_field("padding", 0, m_tdata[55:54]);
                    check_field("final_pick", want.last_pick, m_tlast);
                    check_field("overflow", want.dropped, m_tuser);
                end
            end
            if (s_tvalid && s_tready) begin
                if (stored_count < ssf_pkg::MAX_REQUESTS) begin
                    track_store[stored_count] = s_tdata[ssf_pkg::TRACK_BITS-1:0];
                    stored_count++;
                end else begin
                    dropped_seen = 1'b1;
                end
                if (s_tlast) serve_nearest_first();
            end
        end
        picks_outstanding = pending_picks.size();
    end

endmodule

FILE: sim/tb_shortest_seek_first_scheduler.sv
// Testbench top for the shortest-seek-first scheduler: stimulus, flow control and verdict.
module tb_shortest_seek_first_scheduler;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int HOLD_OFF_AFTER  = 30;
    localparam int DRAIN_CYCLES    = 80;
    localparam int ITEM_TARGET     = 330;

    typedef enum {TRK_SPREAD, TRK_CLUSTER, TRK_REPEAT} track_mix_t;
    typedef enum {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    int          mismatches;
    int          picks_outstanding;
    int          cycle_count   = 0;
    int          results_taken = 0;
    int          requests_sent = 0;
    int          burst_left    = 1;
    logic [15:0] cur_start     = '0;
    logic [15:0] palette [4];

    always #4 aclk = ~aclk;

    shortest_seek_first_scheduler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    ssf_result_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tlast           (s_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .m_tuser           (m_tuser),
        .mismatches        (mismatches),
        .picks_outstanding (picks_outstanding)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (m_tvalid && m_tready) results_taken <= results_taken + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_shortest_seek_first_scheduler failed");
            $finish;
        end
    end

    // One request transfer; the sender pauses at random once its burst runs out.
    task automatic send_request(input logic [15:0] track, input logic last);
        int gap;
        @(negedge aclk);
        s_tdata  = track;
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // The head position is only changed once the scheduler has gone idle.
    task automatic write_start(input logic [15:0] value);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (picks_outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        cur_start = value;
    endtask

    function automatic logic [15:0] next_track(input track_mix_t mix);
        logic [15:0] offset;
        case (mix)
            TRK_CLUSTER: begin
                // Close to the head, wrapping at the ends, so equal distances are common.
                offset = 16'($urandom_range(0, 16));
                return cur_start + offset - 16'd8;
            end
            TRK_REPEAT: return palette[$urandom_range(0, 3)];
            default:    return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin : receiver
        rx_mode_t mode;
        int       stretch;
        bit       held_off;
        held_off = 1'b0;
        wait (aresetn);
        forever begin
            mode    = rx_mode_t'($urandom_range(0, 2));
            stretch = $urandom_range(8, 120);
            repeat (stretch) begin
                @(negedge aclk);
                if (!held_off && results_taken >= HOLD_OFF_AFTER) begin
                    held_off = 1'b1;
                    m_tready = 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                end
                case (mode)
                    RX_STEADY: m_tready = 1'b1;
                    RX_RANDOM: m_tready = 1'($urandom_range(0, 1));
                    default:   m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int         batch_no;
        int         size;
        track_mix_t mix;
        repeat (5) @(negedge aclk);
        aresetn    = 1'b1;
        burst_left = $urandom_range(1, 12);

        // Head at its reset value: both ends of the track range.
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b1);
        // Two requests at equal distance from the head.
        write_start(16'd100);
        send_request(16'd110, 1'b0);
        send_request(16'd90, 1'b0);
        send_request(16'd100, 1'b1);
        // Longest possible seek in a single-request batch.
        write_start(16'hFFFF);
        send_request(16'h0000, 1'b1);
        // Alternating bit patterns with a repeated track.
        write_start(16'h5555);
        send_request(16'hAAAA, 1'b0);
        send_request(16'h5555, 1'b0);
        send_request(16'hAAAA, 1'b1);

        batch_no = 0;
        while (requests_sent < ITEM_TARGET) begin
            // A full store first, then one that overflows with the end marker on a dropped item.
            if (batch_no == 0)
                size = ssf_pkg::MAX_REQUESTS;
            else if (batch_no == 1)
                size = ssf_pkg::MAX_REQUESTS + 2;
            else if ($urandom_range(0, 19) == 0)
                size = $urandom_range(ssf_pkg::MAX_REQUESTS - 4, ssf_pkg::MAX_REQUESTS + 3);
            else
                size = $urandom_range(1, 10);
            mix = track_mix_t'($urandom_range(0, 2));
            for (int i = 0; i < 4; i++) palette[i] = 16'($urandom_range(0, 65535));
            for (int i = 0; i < size; i++) send_request(next_track(mix), i == size - 1);
            batch_no++;
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0:       write_start(16'h0000);
                    1:       write_start(16'hFFFF);
                    default: write_start(16'($urandom_range(0, 65535)));
                endcase
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (picks_outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && picks_outstanding == 0)
            $display("tb_shortest_seek_first_scheduler passed");
        else
            $display("tb_shortest_seek_first_scheduler failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ssf_pkg.sv
rtl/core/ssf_cell.sv
rtl/core/ssf_cell_row.sv
rtl/core/shortest_seek_first_scheduler.sv
sim/ssf_result_checker.sv
sim/tb_shortest_seek_first_scheduler.sv
